// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; each macro takes a label, a clock, an active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/sis_pkg.sv =====
// Package for the sorted insert stack: sizes, codes, the cell control word and the ordering test.
// Depends on nothing; used by every module of the block.
`default_nettype none

package sis_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OUT_CNT_W = 5;
  localparam int ERR_W  = 2;
  localparam int APB_W  = 32;
  localparam int ADDR_W = 3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic MODE_MAX = 1'b0;
  localparam logic MODE_MIN = 1'b1;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;

  localparam logic REG_ORDER_MODE = 1'b0;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    logic  mode;
    data_t value;
  } cell_ctrl_t;

  // True when a stored entry must stay above a newly pushed value.
  function automatic logic stays_above(data_t entry, data_t v, logic mode);
    logic res;
    if (mode == MODE_MIN) begin
      res = (v > entry);
    end else begin
      res = (entry > v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sis_cell.sv =====
// One storage cell of the sorted stack: holds one word and trades it with its neighbours.
// Depends on sis_pkg for the control word and the ordering test.
`default_nettype none

module sis_cell (
  input  wire                      clk,
  input  wire sis_pkg::cell_ctrl_t ctrl,
  input  wire                      occupied,
  input  wire sis_pkg::data_t      upper_d,
  input  wire sis_pkg::data_t      lower_d,
  input  wire                      walk_in,
  output logic                     walk_out,
  output sis_pkg::data_t           data_q
);
  import sis_pkg::*;

  data_t data_r;
  data_t data_nxt;

  assign walk_out = walk_in & occupied & stays_above(data_r, ctrl.value, ctrl.mode);
  assign data_q   = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      if (walk_out) begin
        data_nxt = data_r;
      end else if (walk_in) begin
        data_nxt = ctrl.value;
      end else begin
        data_nxt = upper_d;
      end
    end else if (ctrl.pop) begin
      data_nxt = lower_d;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_insert_stack_top.sv =====
// Result: the result word of an accepted word is shown in the next cycle, from an output register.
// Throughput: one push or pop per cycle while in_stall is low; every cell compares and shifts in the same cycle.
// Reset clears the entry count, the ordering mode and the output valid; the cells are not cleared.
// Top level of the sorted insert stack; depends on sis_pkg and sis_cell.
`default_nettype none

module sorted_insert_stack_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_opcode,
  input  wire signed [sis_pkg::DATA_W-1:0]  in_value,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic signed [sis_pkg::DATA_W-1:0] out_popped_value,
  output logic signed [sis_pkg::DATA_W-1:0] out_top_value,
  output logic [sis_pkg::OUT_CNT_W-1:0]     out_entry_count,
  output logic [sis_pkg::ERR_W-1:0]         out_error_code,
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire [sis_pkg::ADDR_W-1:0]         cfg_paddr,
  input  wire [sis_pkg::APB_W-1:0]          cfg_pwdata,
  output logic [sis_pkg::APB_W-1:0]         cfg_prdata,
  output logic                              cfg_pready
);
  import sis_pkg::*;

  logic                  mode_r;
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;
  logic                  out_valid_r;
  data_t                 popped_r;
  data_t                 top_r;
  logic [OUT_CNT_W-1:0]  cnt_out_r;
  logic [ERR_W-1:0]      err_r;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic                  push_ok;
  logic                  pop_ok;
  data_t                 popped_nxt;
  data_t                 top_nxt;
  logic [ERR_W-1:0]      err_nxt;
  logic [CNT_W+OUT_CNT_W-1:0] cnt_wide;
  logic                  reg_index;
  cell_ctrl_t            ctrl;
  data_t                 cell_q [DEPTH];
  logic [DEPTH:0]        walk;

  assign cfg_pready = 1'b1;
  assign reg_index  = cfg_paddr[ADDR_W-1];
  assign cfg_prdata = (reg_index == REG_ORDER_MODE) ? {{(APB_W-1){1'b0}}, mode_r} : '0;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign push_ok  = accept & (in_opcode == OP_PUSH) & ~full;
  assign pop_ok   = accept & (in_opcode == OP_POP) & ~empty;

  assign ctrl = {push_ok, pop_ok, mode_r, in_value};

  assign walk[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic  occ;
    data_t upper;
    data_t lower;
    assign occ = (CNT_W'(i) < count_r);
    if (i == 0) begin : g_first
      assign upper = in_value;
    end else begin : g_mid
      assign upper = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign lower = cell_q[i];
    end else begin : g_body
      assign lower = cell_q[i+1];
    end
    sis_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (occ),
      .upper_d  (upper),
      .lower_d  (lower),
      .walk_in  (walk[i]),
      .walk_out (walk[i+1]),
      .data_q   (cell_q[i])
    );
  end

  always_comb begin
    count_nxt  = count_r;
    popped_nxt = '0;
    err_nxt    = ERR_OK;
    top_nxt    = empty ? '0 : cell_q[0];
    if (push_ok) begin
      count_nxt = count_r + 1'b1;
      top_nxt   = walk[1] ? cell_q[0] : in_value;
    end else if (pop_ok) begin
      count_nxt  = count_r - 1'b1;
      popped_nxt = cell_q[0];
      top_nxt    = (count_r > CNT_W'(1)) ? cell_q[1] : '0;
    end else if (in_opcode == OP_PUSH) begin
      err_nxt = ERR_FULL;
    end else begin
      err_nxt = ERR_EMPTY;
    end
  end

  assign cnt_wide = {{OUT_CNT_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MAX;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          (reg_index == REG_ORDER_MODE)) begin
        mode_r <= cfg_pwdata[0];
      end
      if (accept) begin
        count_r <= count_nxt;
      end
      out_valid_r <= accept | in_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r  <= popped_nxt;
      top_r     <= top_nxt;
      cnt_out_r <= cnt_wide[OUT_CNT_W-1:0];
      err_r     <= err_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_top_value    = top_r;
  assign out_entry_count  = cnt_out_r;
  assign out_error_code   = err_r;

endmodule

`default_nettype wire

// ===== hdl/sis_checker.sv =====
// Port-level checker for the sorted insert stack, bound to the top level.
// Depends on sis_pkg and the macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sis_checker (
  input wire                               clk,
  input wire                               rst_n,
  input wire                               out_valid,
  input wire                               out_stall,
  input wire signed [sis_pkg::DATA_W-1:0]  out_popped_value,
  input wire signed [sis_pkg::DATA_W-1:0]  out_top_value,
  input wire [sis_pkg::OUT_CNT_W-1:0]      out_entry_count,
  input wire [sis_pkg::ERR_W-1:0]          out_error_code
);
  import sis_pkg::*;

  localparam logic [OUT_CNT_W-1:0] FULL_CNT = OUT_CNT_W'(DEPTH % (2 ** OUT_CNT_W));

  `SIS_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_top_value))
  `SIS_ASSERT_IMP(a_empty_err, clk, rst_n, out_valid && (out_error_code == ERR_EMPTY), (out_entry_count == '0) && (out_popped_value == '0))
  `SIS_ASSERT_IMP(a_full_err, clk, rst_n, out_valid && (out_error_code == ERR_FULL), (out_entry_count == FULL_CNT) && (out_popped_value == '0))
  `SIS_ASSERT_IMP(a_err_code, clk, rst_n, out_valid, (out_error_code == ERR_OK) || (out_error_code == ERR_FULL) || (out_error_code == ERR_EMPTY))

endmodule

bind sorted_insert_stack_top sis_checker u_sis_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_popped_value (out_popped_value),
  .out_top_value    (out_top_value),
  .out_entry_count  (out_entry_count),
  .out_error_code   (out_error_code)
);

`default_nettype wire

// ===== bench/sorted_insert_stack_top_test.sv =====
// Self-checking testbench for sorted_insert_stack_top: directed and random push and pop words,
// random idling on both channels, and ordering-mode writes over the APB-style port.
// Depends on sis_pkg and the RTL of the sorted insert stack; it reads no file.
`timescale 1ns / 1ps

module sorted_insert_stack_top_test;
  import sis_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam logic [ADDR_W-1:0] ORDER_MODE_ADDR = ADDR_W'(4 * REG_ORDER_MODE);
  localparam logic [ADDR_W-1:0] SPARE_REG_ADDR  = ADDR_W'(4);

  typedef struct {
    data_t                popped;
    data_t                top;
    logic [OUT_CNT_W-1:0] count;
    logic [ERR_W-1:0]     err;
  } stack_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_PUSH;
  data_t                 in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  data_t                 out_popped_value;
  data_t                 out_top_value;
  logic [OUT_CNT_W-1:0]  out_entry_count;
  logic [ERR_W-1:0]      out_error_code;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0]     cfg_paddr = '0;
  logic [APB_W-1:0]      cfg_pwdata = '0;
  logic [APB_W-1:0]      cfg_prdata;
  logic                  cfg_pready;

  data_t         shadow_entries [DEPTH];
  int            shadow_count = 0;
  logic          shadow_mode = MODE_MAX;
  stack_result_t pending_results [$];

  bit pace_on = 1'b1;
  int hold_request = 0;
  int cycle_count = 0;
  int error_count = 0;
  int words_sent = 0;
  int results_checked = 0;
  int full_pushes = 0;
  int empty_pops = 0;
  int mode_writes = 0;

  sorted_insert_stack_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_popped_value(out_popped_value),
    .out_top_value(out_top_value), .out_entry_count(out_entry_count),
    .out_error_code(out_error_code),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out waiting for the block", $time);
      $display("sorted_insert_stack_top verification failed");
      $finish;
    end
  end

  // Shadow of the stack: updates the stored entries and returns the result word.
  function automatic stack_result_t sorted_stack_step(logic op, data_t v);
    stack_result_t r;
    int pos;
    r.popped = '0;
    r.err = ERR_OK;
    if (op == OP_PUSH) begin
      if (shadow_count >= DEPTH) begin
        r.err = ERR_FULL;
        full_pushes++;
      end else begin
        pos = shadow_count;
        while (pos > 0 && ((shadow_mode == MODE_MIN) ? (v > shadow_entries[pos-1])
                                                     : (shadow_entries[pos-1] > v))) begin
          shadow_entries[pos] = shadow_entries[pos-1];
          pos--;
        end
        shadow_entries[pos] = v;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.err = ERR_EMPTY;
      empty_pops++;
    end else begin
      shadow_count--;
      r.popped = shadow_entries[shadow_count];
    end
    r.top = (shadow_count > 0) ? shadow_entries[shadow_count-1] : data_t'(0);
    r.count = OUT_CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic data_t pick_value();
    int s;
    s = $urandom_range(0, 8);
    case ($urandom_range(0, 5))
      0: return data_t'(32'h7fff_ffff);
      1: return data_t'(32'h8000_0000);
      2: return data_t'(s - 4);
      default: return data_t'($urandom);
    endcase
  endfunction

  // Offers one word and waits until the block takes it; valid stays high for a word that follows.
  task automatic send_word(logic op, data_t v);
    int gap;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(sorted_stack_step(op, v));
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [APB_W-1:0] data);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ORDER_MODE_ADDR) begin
      shadow_mode = data[0];
      mode_writes++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_check_mode();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= ORDER_MODE_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== APB_W'(shadow_mode)) begin
      $display("%0t: order_mode read expected %0d, got %0d", $time, shadow_mode, cfg_prdata);
      error_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic report_mismatch(string field, longint want, longint got);
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    error_count++;
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected, top %0d count %0d", $time,
                 out_top_value, out_entry_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_popped_value !== want.popped)
          report_mismatch("popped_value", longint'(want.popped), longint'(out_popped_value));
        if (out_top_value !== want.top)
          report_mismatch("top_value", longint'(want.top), longint'(out_top_value));
        if (out_entry_count !== want.count)
          report_mismatch("entry_count", longint'(want.count), longint'(out_entry_count));
        if (out_error_code !== want.err)
          report_mismatch("error_code", longint'(want.err), longint'(out_error_code));
      end
    end
  end

  // Receiver: a random hold before each word, or a long hold when one is requested.
  initial begin
    int wait_cycles;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      wait_cycles = pace_on ? $urandom_range(0, 3) : 0;
      if (hold_request > 0) begin
        wait_cycles = hold_request;
        hold_request = 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic test_reset_state();
    cfg_check_mode();
    send_word(OP_POP, data_t'(32'h1234_5678));
    wait_for_results();
  endtask

  // Extremes, a tie and pops in max mode; four entries are left for the mode change.
  task automatic test_push_pop_extremes();
    send_word(OP_PUSH, data_t'(32'h7fff_ffff));
    send_word(OP_PUSH, data_t'(32'h8000_0000));
    send_word(OP_PUSH, data_t'(0));
    send_word(OP_PUSH, data_t'(-1));
    send_word(OP_PUSH, data_t'(1));
    send_word(OP_PUSH, data_t'(1));
    send_word(OP_POP, data_t'(32'hffff_ffff));
    send_word(OP_POP, data_t'(0));
    wait_for_results();
  endtask

  task automatic test_register_access();
    cfg_write(SPARE_REG_ADDR, 32'h0000_0001);
    cfg_check_mode();
    cfg_write(ORDER_MODE_ADDR, 32'hffff_fffe);
    cfg_check_mode();
    cfg_write(ORDER_MODE_ADDR, 32'h0000_0001);
    cfg_check_mode();
  endtask

  // The stored entries stay put while later pushes sort under the new mode.
  task automatic test_mode_change_with_entries();
    send_word(OP_PUSH, data_t'(2));
    send_word(OP_PUSH, data_t'(32'h8000_0000));
    send_word(OP_PUSH, data_t'(-1));
    send_word(OP_PUSH, data_t'(32'h7fff_ffff));
    send_word(OP_POP, data_t'(0));
    repeat (shadow_count + 1) send_word(OP_POP, pick_value());
    wait_for_results();
  endtask

  task automatic test_random_traffic(logic mode, int n_words);
    int sent;
    int pushes;
    int pops;
    sent = 0;
    cfg_write(ORDER_MODE_ADDR, {(APB_W-1)'($urandom), mode});
    cfg_check_mode();
    while (sent < n_words) begin
      pace_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 9) < 7) begin
        pushes = $urandom_range(1, 20);
        pops = $urandom_range(1, pushes + 2);
        repeat (pushes) send_word(OP_PUSH, pick_value());
        repeat (pops) send_word(OP_POP, pick_value());
        sent += pushes + pops;
      end else begin
        pushes = $urandom_range(1, 8);
        repeat (pushes) send_word(logic'($urandom_range(0, 1)), pick_value());
        sent += pushes;
      end
    end
    pace_on = 1'b1;
    wait_for_results();
  endtask

  task automatic test_receiver_hold();
    hold_request = 150;
    repeat (40) send_word(logic'($urandom_range(0, 1)), pick_value());
    wait_for_results();
  endtask

  task automatic test_sender_drain_pause();
    repeat (12) send_word(OP_PUSH, pick_value());
    wait_for_results();
    repeat (12) send_word(logic'($urandom_range(0, 1)), pick_value());
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_push_pop_extremes();
    test_register_access();
    test_mode_change_with_entries();
    test_random_traffic(MODE_MAX, 400);
    test_receiver_hold();
    test_random_traffic(MODE_MIN, 400);
    test_sender_drain_pause();
    test_random_traffic(MODE_MAX, 400);
    test_receiver_hold();
    repeat (4) @(posedge clk);
    $display("Sent %0d words in both orderings and checked %0d results.", words_sent,
             results_checked);
    $display("Saw %0d pushes on a full stack, %0d pops on an empty one, %0d mode writes.",
             full_pushes, empty_pops, mode_writes);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("sorted_insert_stack_top verification clean");
    end else begin
      $display("sorted_insert_stack_top verification failed");
    end
    $finish;
  end

endmodule
